// ===== rtl/core/ate_pkg.sv =====
// package for the array table engine: operation codes, status codes, widths
`default_nettype none
package ate_pkg;
  localparam int WordW = 32;
  localparam int SumW  = 37;

  typedef enum logic [3:0] {
    K_APPEND = 4'd0, K_INSERT = 4'd1, K_DELETE = 4'd2, K_GET = 4'd3,
    K_SET = 4'd4, K_SEARCH = 4'd5, K_TSEARCH = 4'd6, K_BSEARCH = 4'd7,
    K_MIN = 4'd8, K_MAX = 4'd9, K_SUM = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_RANGE = 2'd1, ST_FULL = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_up;
    logic shift_dn;
    logic wr_en;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/ate_if.sv =====
// valid/ready channel interfaces for the array table engine
`default_nettype none
interface ate_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [5:0]  position_in;
  logic signed [31:0] operand;
  modport source (output valid, kind, position_in, operand, input ready);
  modport sink   (input valid, kind, position_in, operand, output ready);
endinterface

interface ate_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [4:0]  position_out;
  logic signed [31:0] element;
  logic signed [36:0] total;
  logic [5:0]  fill;
  modport source (output valid, status, found, position_out, element, total, fill,
                  input ready);
  modport sink   (input valid, status, found, position_out, element, total, fill,
                  output ready);
endinterface

interface ate_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ate_cell.sv =====
// one storage cell of the element chain
`default_nettype none
module ate_cell import ate_pkg::*; (
  input  wire logic                    clk,
  input  wire cell_cmd_t               cmd,
  input  wire logic                    sel,
  input  wire logic                    shift_en,
  input  wire logic signed [WordW-1:0] wr_data,
  input  wire logic signed [WordW-1:0] from_below,
  input  wire logic signed [WordW-1:0] from_above,
  output logic signed [WordW-1:0]      q
);
  logic signed [WordW-1:0] data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && sel) begin
      data_r <= wr_data;
    end else if (cmd.shift_up && shift_en) begin
      data_r <= from_below;
    end else if (cmd.shift_dn && shift_en) begin
      data_r <= from_above;
    end
  end

  assign q = data_r;
endmodule
`default_nettype wire

// ===== rtl/core/array_table_engine_core.sv =====
// array table engine top level: sequencer over a chain of element cells
//  channel | dir | transfer when   | payload
//  in      | in  | valid && ready  | kind, position_in, operand
//  out     | out | valid && ready  | status, found, position_out, element, total, fill
//  cfg     | in  | valid && ready  | data (capacity)
// append, insert, delete, get, set go from idle through S_OUT; insert and delete shift the chain at accept
// scans (search, tsearch, min, max, sum) read one element a cycle
// binary search takes one probe a cycle
// one item at a time; input ready only when idle with the output register empty
// reset clears length and sets capacity to 32; element storage is not cleared
`default_nettype none
module array_table_engine_core import ate_pkg::*; #(
  parameter int CAP = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  ate_in_if.sink    in_ch,
  ate_out_if.source out_ch,
  ate_cfg_if.sink   cfg_ch
);
  localparam int LW = $clog2(CAP + 1);
  localparam int IW = $clog2(CAP);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_BIN, S_OUT} state_t;

  state_t state_r;
  logic [5:0] cap_r;
  logic [LW-1:0] len_r;
  logic [3:0] kind_r;
  logic signed [WordW-1:0] opd_r;
  logic [LW-1:0] idx_r;
  logic signed [LW:0] lo_r, hi_r;
  logic [1:0] st_r;
  logic fnd_r;
  logic [4:0] where_r;
  logic signed [WordW-1:0] elem_r;
  logic signed [SumW-1:0] tot_r;

  logic signed [WordW-1:0] q [CAP];
  cell_cmd_t cmd;
  logic [IW-1:0] wr_idx;
  logic signed [WordW-1:0] wr_data;
  logic [LW-1:0] limit;
  logic in_fire;

  assign limit = ({{(LW > 6 ? LW-6 : 0){1'b0}}, cap_r} < LW'(CAP)) ?
                 LW'(cap_r) : LW'(CAP);
  assign in_ch.ready = (state_r == S_IDLE) && !out_ch.valid;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // read port
  logic [IW-1:0] rd_idx;
  logic signed [LW+1:0] mid_sum;
  logic signed [LW:0] mid;
  logic signed [WordW-1:0] rd;
  assign mid_sum = lo_r + hi_r;
  assign mid = mid_sum[LW+1:1];
  assign rd_idx = (state_r == S_BIN) ? mid[IW-1:0] : idx_r[IW-1:0];
  assign rd = q[rd_idx];

  // cell command generation
  logic [LW-1:0] pos_l;
  logic ok_ins, ok_del, ok_app, ok_set;
  assign pos_l = LW'(in_ch.position_in);
  assign ok_app = (in_ch.kind == K_APPEND) && (len_r < limit);
  assign ok_ins = (in_ch.kind == K_INSERT) && (pos_l <= len_r) &&
                  ({1'b0, in_ch.position_in} <= (LW+1)'(len_r)) && (len_r < limit);
  assign ok_del = (in_ch.kind == K_DELETE) &&
                  ({1'b0, in_ch.position_in} < (LW+1)'(len_r));
  assign ok_set = (in_ch.kind == K_SET) &&
                  ({1'b0, in_ch.position_in} < (LW+1)'(len_r));

  logic swap_lo, swap_hi;
  always_comb begin
    cmd = '0;
    wr_idx = in_ch.position_in[IW-1:0];
    wr_data = in_ch.operand;
    swap_lo = 1'b0;
    swap_hi = 1'b0;
    if (in_fire) begin
      cmd.wr_en = ok_app || ok_ins || ok_set;
      if (ok_app) wr_idx = len_r[IW-1:0];
      cmd.shift_up = ok_ins;
      cmd.shift_dn = ok_del;
    end else if (state_r == S_SCAN && kind_r == K_TSEARCH && rd == opd_r &&
                 idx_r != '0 && idx_r < len_r) begin
      swap_hi = 1'b1;
      swap_lo = 1'b1;
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic sel, sh;
    logic signed [WordW-1:0] below, above, wd;
    cell_cmd_t c;
    always_comb begin
      below = (g == 0) ? q[0] : q[(g == 0) ? 0 : g-1];
      above = (g == CAP-1) ? q[CAP-1] : q[(g == CAP-1) ? CAP-1 : g+1];
      c = cmd;
      sel = (wr_idx == IW'(g));
      wd = wr_data;
      if (cmd.shift_up) sh = (IW'(g) > wr_idx) && (LW'(g) <= len_r);
      else sh = (IW'(g) >= wr_idx);
      if (swap_hi && idx_r[IW-1:0] == IW'(g)) begin
        c.wr_en = 1'b1; sel = 1'b1; wd = q[(g == 0) ? 0 : g-1];
      end else if (swap_lo && idx_r[IW-1:0] == IW'(g + 1)) begin
        c.wr_en = 1'b1; sel = 1'b1; wd = rd;
      end
    end
    ate_cell u_cell (
      .clk(clk), .cmd(c), .sel(sel), .shift_en(sh), .wr_data(wd),
      .from_below(below), .from_above(above), .q(q[g])
    );
  end

  logic [1:0] st_n;
  always_comb begin
    st_n = ST_OK;
    case (in_ch.kind)
      K_APPEND: st_n = (len_r < limit) ? ST_OK : ST_FULL;
      K_INSERT: st_n = ({1'b0, in_ch.position_in} > (LW+1)'(len_r)) ? ST_RANGE :
                       (len_r >= limit) ? ST_FULL : ST_OK;
      K_DELETE, K_GET, K_SET:
        st_n = (len_r == '0) ? ST_EMPTY :
               ({1'b0, in_ch.position_in} >= (LW+1)'(len_r)) ? ST_RANGE : ST_OK;
      K_MIN, K_MAX: st_n = (len_r == '0) ? ST_EMPTY : ST_OK;
      default: st_n = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= 6'd32;
      len_r <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid) cap_r <= cfg_ch.data;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r <= in_ch.kind;
            opd_r <= in_ch.operand;
            st_r <= st_n;
            fnd_r <= 1'b0;
            where_r <= '0;
            elem_r <= '0;
            tot_r <= '0;
            idx_r <= '0;
            lo_r <= '0;
            hi_r <= (LW+1)'(len_r) - 1'b1;
            if (ok_app || ok_ins) len_r <= len_r + 1'b1;
            if (ok_del) len_r <= len_r - 1'b1;
            if ((ok_del || in_ch.kind == K_GET) && st_n == ST_OK) begin
              elem_r <= q[in_ch.position_in[IW-1:0]];
            end
            case (in_ch.kind)
              K_SEARCH, K_TSEARCH, K_SUM: state_r <= S_SCAN;
              K_MIN, K_MAX: state_r <= (st_n == ST_OK) ? S_SCAN : S_OUT;
              K_BSEARCH: state_r <= S_BIN;
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          if (idx_r >= len_r) begin
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + 1'b1;
            case (kind_r)
              K_SUM: tot_r <= tot_r + SumW'(rd);
              K_MIN: if (idx_r == '0 || rd < elem_r) elem_r <= rd;
              K_MAX: if (idx_r == '0 || rd > elem_r) elem_r <= rd;
              default: if (rd == opd_r) begin
                fnd_r <= 1'b1;
                where_r <= 5'(idx_r);
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_BIN: begin
          if (lo_r > hi_r) begin
            state_r <= S_OUT;
          end else if (rd == opd_r) begin
            fnd_r <= 1'b1;
            where_r <= 5'(mid);
            state_r <= S_OUT;
          end else if (opd_r < rd) begin
            hi_r <= mid - 1'b1;
          end else begin
            lo_r <= mid + 1'b1;
          end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.status = st_r;
  assign out_ch.found = fnd_r;
  assign out_ch.position_out = where_r;
  assign out_ch.element = elem_r;
  assign out_ch.total = tot_r;
  assign out_ch.fill = 6'(len_r);

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAP)) else $error("fill above storage depth");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> state_r == S_IDLE) else $error("result shown while busy");
  a_found_st: assert property (@(posedge clk) disable iff (!rst_n)
    fnd_r && out_ch.valid |-> st_r == ST_OK) else $error("hit with fault status");
endmodule
`default_nettype wire
